// File: design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the LRU key-value cache
// Field widths, command codes, the controller state type and the per-cell
// control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE
   } state_type;

   // Control handed to one cell of the chain.
   typedef struct packed {
      logic live;    // the cell holds a valid entry
      logic shift;   // take the neighbor's entry at this edge
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// A chain of rank cells, most recent entry first, driven by a small
// controller that looks up, promotes, inserts and evicts.
// ----------------------------------------------------------------------------
// Usage notes.
// Requests arrive on the req_ channel (req_cmd, req_key, req_value) and are
// transferred at a rising edge with req_valid high and req_stall low. Every
// request produces exactly one response on the rsp_ channel (rsp_hit,
// rsp_read_value), transferred when rsp_valid is high and rsp_stall low.
// The capacity register is written through csr_valid / csr_wdata; csr_ready
// is always high, and writes belong in idle periods.
// Timing: a request transferred at an edge is looked up during the next
// cycle, and its response is registered when its update step finishes.
// A new request is not accepted before the previous one is through: the
// cycle that writes the update into the chain also accepts the next request,
// and the following cycle compares that request against the updated chain.
// This lookup-then-update pair sets how often requests can be taken.
// When the receiver stalls with a response still held, the update step of
// the next request waits, and req_stall stays high until it can finish.
// Reset (synchronous, active high) empties the store, sets capacity to 4
// and drops any request or response in flight. No clearing pass is needed:
// validity follows from the entry count alone.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_cmd,
   input  wire logic signed [KEY_W-1:0] req_key,
   input  wire logic signed [VAL_W-1:0] req_value,
   // response channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_hit,
   output logic signed [VAL_W-1:0]      rsp_read_value,
   // capacity register write channel
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CAP_W-1:0]        csr_wdata
);

   // The count must be able to hold MAX_ENTRIES itself.
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W + 1 > CAP_W) ? CNT_W + 1 : CAP_W;
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] RANK_TOP = CNT_W'(MAX_ENTRIES - 1);

   // Controller state.
   state_type state_ff;
   state_type state_in;

   // Registered request.
   logic                    req_cmd_ff;
   logic signed [KEY_W-1:0] req_key_ff;
   logic signed [VAL_W-1:0] req_value_ff;

   // Lookup results, registered at the end of the lookup cycle.
   logic                    hit_ff;
   logic                    hit_in;
   logic [CNT_W-1:0]        hit_rank_ff;
   logic [CNT_W-1:0]        hit_rank_in;
   logic signed [VAL_W-1:0] hit_value_ff;
   logic signed [VAL_W-1:0] hit_value_in;

   // Number of valid entries; they occupy ranks 0 to count-1.
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CAP_W-1:0] capacity_ff;

   // Response register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_hit_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;

   // Handshake and step signals.
   logic req_xfer;
   logic upd_go;
   logic load_req;

   // Chain signals.
   cell_ctrl_type           cell_ctrl  [MAX_ENTRIES];
   logic signed [KEY_W-1:0] cell_key   [MAX_ENTRIES];
   logic signed [VAL_W-1:0] cell_value [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]  cell_match;
   logic signed [VAL_W-1:0] head_value;
   logic [CNT_W-1:0]        shift_limit;
   logic                    shift_on;

   // The update step finishes only when the response slot is free or is
   // being emptied in this very cycle.
   assign upd_go   = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign req_xfer = req_valid && !req_stall;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_go) state_in = req_valid ? ST_LOOK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output logic of the controller.
   always_comb begin
      req_stall = 1'b1;
      load_req  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            load_req  = req_valid;
         end
         ST_LOOK: begin
            req_stall = 1'b1;
         end
         ST_UPDATE: begin
            req_stall = !upd_go;
            load_req  = upd_go && req_valid;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_req) begin
         req_cmd_ff   <= req_cmd;
         req_key_ff   <= req_key;
         req_value_ff <= req_value;
      end
   end

   // Gather the lookup: at most one live cell can match, so the rank and
   // the value fold together with plain OR trees.
   always_comb begin
      hit_in       = |cell_match;
      hit_rank_in  = '0;
      hit_value_in = '0;
      for (int r = 0; r < MAX_ENTRIES; r++) begin
         if (cell_match[r]) begin
            hit_rank_in  = hit_rank_in | CNT_W'(r);
            hit_value_in = hit_value_in | cell_value[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOK) begin
         hit_ff       <= hit_in;
         hit_rank_ff  <= hit_rank_in;
         hit_value_ff <= hit_value_in;
      end
   end

   // Promotion moves ranks 0 to shift_limit down by one and puts the
   // request's entry at rank 0. A hit promotes from its own rank; a new key
   // enters at rank count, or drops the least recent entry when the chain
   // is full. A missed get leaves the chain alone.
   always_comb begin
      shift_on    = upd_go && (hit_ff || (req_cmd_ff == CMD_PUT));
      shift_limit = hit_ff ? hit_rank_ff :
                    ((count_ff == CNT_MAX) ? RANK_TOP : count_ff);
      head_value  = (req_cmd_ff == CMD_PUT) ? req_value_ff : hit_value_ff;
   end

   // A new key grows the count unless the chain is full or the capacity is
   // already reached; in either case the least recent entry falls out.
   always_comb begin
      count_in = count_ff;
      if (upd_go && !hit_ff && (req_cmd_ff == CMD_PUT)) begin
         if ((count_ff != CNT_MAX) &&
             ((CMP_W'(count_ff) + CMP_W'(1)) <= CMP_W'(capacity_ff))) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         capacity_ff <= CAP_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   assign csr_ready = 1'b1;

   // The chain of rank cells, rank 0 most recent.
   for (genvar r = 0; r < MAX_ENTRIES; r++) begin : g_cell
      always_comb begin
         cell_ctrl[r].live  = CNT_W'(r) < count_ff;
         cell_ctrl[r].shift = shift_on && (CNT_W'(r) <= shift_limit);
      end

      if (r == 0) begin : g_head
         lkv_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[r]),
            .probe_key  (req_key_ff),
            .prev_key   (req_key_ff),
            .prev_value (head_value),
            .key_out    (cell_key[r]),
            .value_out  (cell_value[r]),
            .match      (cell_match[r])
         );
      end else begin : g_body
         lkv_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[r]),
            .probe_key  (req_key_ff),
            .prev_key   (cell_key[r-1]),
            .prev_value (cell_value[r-1]),
            .key_out    (cell_key[r]),
            .value_out  (cell_value[r]),
            .match      (cell_match[r])
         );
      end
   end

   // Response register: loaded when the update step finishes, emptied by a
   // transfer on the response channel.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_go) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= (hit_ff && (req_cmd_ff == CMD_GET)) ? hit_value_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

`default_nettype wire

// File: design/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell: one rank position of the recency chain
// Holds one key and value, compares its key with the probe key and takes
// the entry of its more recent neighbor when told to shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell
   import lkv_pkg::*;
(
   input  wire logic                    clock,
   input  wire cell_ctrl_type           ctrl,
   input  wire logic signed [KEY_W-1:0] probe_key,
   input  wire logic signed [KEY_W-1:0] prev_key,
   input  wire logic signed [VAL_W-1:0] prev_value,
   output logic signed [KEY_W-1:0]      key_out,
   output logic signed [VAL_W-1:0]      value_out,
   output logic                         match
);

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;
   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;

   always_comb begin
      key_in   = ctrl.shift ? prev_key   : key_ff;
      value_in = ctrl.shift ? prev_value : value_ff;
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign match     = ctrl.live && (key_ff == probe_key);
   assign key_out   = key_ff;
   assign value_out = value_ff;

endmodule

`default_nettype wire

// File: design/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker: port-level checks of the LRU key-value cache
// Watches the top level's channels over time; attached by a bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_checker
   import lkv_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic                    rsp_hit,
   input wire logic signed [VAL_W-1:0] rsp_read_value
);

   // After reset no response is pending.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response pending right after reset");

   // A request transfer is followed by a lookup cycle that takes nothing.
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken during lookup cycle");

   // A miss never returns data. Put hits return none either, but this property checks misses only.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_read_value == '0))
      else $error("miss response carries data");

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response withdrawn");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for lru_key_value_cache
// A queue-fed request driver and a response monitor run as clocked always
// blocks. A behavioral LRU store predicts every response. The run sweeps the
// capacity register through its extremes and idles both channels at random.
// ----------------------------------------------------------------------------

module tb_top;
   import lkv_pkg::*;

   localparam int CACHE_DEPTH = 16;
   localparam int HALF_PERIOD = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int POOL_SIZE = 24;

   typedef struct packed {
      logic             cmd;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } cache_req_type;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] read_value;
   } cache_resp_type;

   // Clock, reset and every block input start at a known value.
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_cmd = CMD_GET;
   logic signed [KEY_W-1:0] req_key = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_hit;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CAP_W-1:0]        csr_wdata = '0;

   lru_key_value_cache #(
      .MAX_ENTRIES(CACHE_DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Behavioral copy of the cache. The store is kept as slot arrays plus a
   // rank list: rank 0 names the most recent slot, and the first lru_count
   // ranks name the live slots.
   // ------------------------------------------------------------------------
   logic [KEY_W-1:0] lru_key  [CACHE_DEPTH];
   logic [VAL_W-1:0] lru_val  [CACHE_DEPTH];
   logic             lru_live [CACHE_DEPTH];
   logic [3:0]       lru_rank_slot [CACHE_DEPTH];
   int               lru_count;
   logic [CAP_W-1:0] lru_capacity;

   cache_req_type  request_queue[$];
   cache_resp_type lookup_results_due[$];
   cache_req_type  next_req;
   cache_resp_type due_resp;

   int          req_gap_left = 0;
   int          rsp_stall_left = 0;
   int          stall_draw;
   bit          steady_flow = 1'b0;
   int          n_fail = 0;
   int          n_requests = 0;
   int          n_checked = 0;
   int          n_hits = 0;
   int          n_evictions = 0;
   int          n_settings = 0;
   int          cycle_count = 0;

   // Moves the slot at the given rank to the front; the ranks above it slide
   // down by one.
   function automatic void move_to_front(int rank);
      logic [3:0] slot;
      slot = lru_rank_slot[rank];
      for (int r = rank; r > 0; r--)
         lru_rank_slot[r] = lru_rank_slot[r-1];
      lru_rank_slot[0] = slot;
   endfunction

   // Applies one get or put to the behavioral store and returns the response
   // that the block must produce for it.
   function automatic cache_resp_type lru_lookup_update(logic cmd, logic [KEY_W-1:0] key,
                                                        logic [VAL_W-1:0] value);
      cache_resp_type resp;
      int             found;
      logic [3:0]     slot;
      resp.hit = 1'b0;
      resp.read_value = '0;
      found = -1;
      for (int r = 0; r < lru_count && r < CACHE_DEPTH && found < 0; r++) begin
         slot = lru_rank_slot[r];
         if (lru_live[slot] && lru_key[slot] == key)
            found = r;
      end
      if (found >= 0) begin
         slot = lru_rank_slot[found];
         resp.hit = 1'b1;
         if (cmd == CMD_GET)
            resp.read_value = lru_val[slot];
         else
            lru_val[slot] = value;
         move_to_front(found);
      end else if (cmd == CMD_PUT) begin
         if (lru_count >= CACHE_DEPTH) begin
            // Full store: the least recent slot is reused in place and the
            // count does not change, whatever the capacity says.
            slot = lru_rank_slot[CACHE_DEPTH-1];
            lru_key[slot] = key;
            lru_val[slot] = value;
            lru_live[slot] = 1'b1;
            move_to_front(CACHE_DEPTH-1);
            n_evictions++;
         end else begin
            slot = lru_rank_slot[lru_count];
            lru_key[slot] = key;
            lru_val[slot] = value;
            lru_live[slot] = 1'b1;
            move_to_front(lru_count);
            lru_count++;
            // At most one entry leaves per insert, even when the capacity
            // has been lowered well below the count.
            if (lru_count > lru_capacity) begin
               lru_count--;
               lru_live[lru_rank_slot[lru_count]] = 1'b0;
               n_evictions++;
            end
         end
      end
      return resp;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. A transfer happens at an edge with req_valid high and
   // req_stall low; the prediction is made at that edge from the payload that
   // was held. Each item carries a gap of idle cycles that follows it.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            lookup_results_due.push_back(lru_lookup_update(req_cmd, req_key, req_value));
            n_requests++;
         end
         // The channel is free unless a stalled payload is still waiting.
         if (!req_valid || !req_stall) begin
            if (req_gap_left > 0) begin
               req_valid <= 1'b0;
               req_gap_left <= req_gap_left - 1;
            end else if (request_queue.size() != 0) begin
               next_req = request_queue.pop_front();
               req_valid <= 1'b1;
               req_cmd <= next_req.cmd;
               req_key <= next_req.key;
               req_value <= next_req.value;
               req_gap_left <= steady_flow ? 0 : $urandom_range(0, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor. Every transfer is matched against the oldest predicted
   // response. After each transfer a fresh stall length is drawn for the next
   // one.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lookup_results_due.size() == 0) begin
               $error("response transfer with no request outstanding: hit %0b, read_value %0d",
                      rsp_hit, rsp_read_value);
               n_fail++;
            end else begin
               due_resp = lookup_results_due.pop_front();
               if (rsp_hit !== due_resp.hit) begin
                  $error("rsp_hit mismatch: expected %0b, actual %0b", due_resp.hit, rsp_hit);
                  n_fail++;
               end
               if (rsp_read_value !== due_resp.read_value) begin
                  $error("rsp_read_value mismatch: expected %0d, actual %0d",
                         $signed(due_resp.read_value), rsp_read_value);
                  n_fail++;
               end
               n_checked++;
               if (due_resp.hit)
                  n_hits++;
            end
            stall_draw = steady_flow ? 0 : $urandom_range(0, 9);
         end else begin
            stall_draw = rsp_stall_left;
         end
         rsp_stall <= (stall_draw > 0);
         rsp_stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic queue_req(input logic cmd, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
      cache_req_type item;
      item.cmd = cmd;
      item.key = key;
      item.value = value;
      request_queue.push_back(item);
   endtask

   // Holds off new requests until every queued request has been transferred
   // and every predicted response has arrived, then lets the pipeline settle.
   task automatic wait_drained();
      @(negedge clock);
      while (request_queue.size() != 0 || req_valid || lookup_results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes the capacity register; only called with the block idle.
   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      lru_capacity = cap;
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus. A short directed part covers the empty store, a zero capacity,
   // the key and value extremes, update hits and an eviction. Random phases
   // then sweep the capacity, including zero, the depth and values above it.
   // Keys come mostly from a small pool so that hits and evictions are
   // frequent; the rest are fully random.
   // ------------------------------------------------------------------------
   initial begin
      logic [CAP_W-1:0] phase_caps [10];
      logic [KEY_W-1:0] key_pool [POOL_SIZE];
      logic [KEY_W-1:0] key_min;
      logic [KEY_W-1:0] key_max;
      int               pool_n;
      logic             cmd;
      logic [KEY_W-1:0] key;

      phase_caps = '{5'd2, 5'd16, 5'd31, 5'd1, 5'd7, 5'd0, 5'd20, 5'd3, 5'd12, 5'd16};
      key_min = 32'h8000_0000;
      key_max = 32'h7FFF_FFFF;

      // Predictor at its reset state: empty store, identity rank order.
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         lru_key[i] = '0;
         lru_val[i] = '0;
         lru_live[i] = 1'b0;
         lru_rank_slot[i] = i[3:0];
      end
      lru_count = 0;
      lru_capacity = CAP_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Zero capacity on an empty store: the new key is dropped at once.
      set_capacity(5'd0);
      queue_req(CMD_GET, 32'd0, 32'd0);
      queue_req(CMD_PUT, key_min, key_max);
      queue_req(CMD_GET, key_min, $urandom);
      wait_drained();

      // Capacity 4: fill with the extremes, touch the oldest, then insert a
      // fifth key so that the least recent entry leaves.
      set_capacity(5'd4);
      queue_req(CMD_PUT, key_min, key_max);
      queue_req(CMD_PUT, key_max, key_min);
      queue_req(CMD_PUT, 32'd0, 32'd0);
      queue_req(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(CMD_GET, key_min, $urandom);
      queue_req(CMD_PUT, 32'd5, 32'd77);
      queue_req(CMD_GET, key_max, $urandom);
      queue_req(CMD_PUT, 32'hFFFF_FFFF, 32'd123);
      queue_req(CMD_GET, 32'hFFFF_FFFF, $urandom);
      queue_req(CMD_GET, 32'd5, 32'hFFFF_FFFF);
      queue_req(CMD_GET, key_min, 32'd0);
      wait_drained();

      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      key_pool[0] = key_min;
      key_pool[1] = key_max;
      key_pool[2] = 32'd0;
      key_pool[3] = 32'hFFFF_FFFF;

      // Each phase waits for the pipeline to drain before the register is
      // touched, so the sender pauses with nothing left outstanding.
      for (int p = 0; p < 10; p++) begin
         set_capacity(phase_caps[p]);
         steady_flow = (p % 4 == 2);
         for (int i = 0; i < 6; i++)
            key_pool[$urandom_range(4, POOL_SIZE-1)] = $urandom;
         pool_n = int'(phase_caps[p]) + 4;
         if (pool_n > POOL_SIZE)
            pool_n = POOL_SIZE;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
            if ($urandom_range(0, 99) < 85)
               key = key_pool[$urandom_range(0, pool_n-1)];
            else
               key = $urandom;
            queue_req(cmd, key, $urandom);
         end
         wait_drained();
      end
      steady_flow = 1'b0;

      $display("Checked %0d responses to %0d requests, %0d of them hits.",
               n_checked, n_requests, n_hits);
      $display("Swept %0d capacity settings from 0 to 31; %0d entries were displaced.",
               n_settings, n_evictions);
      if (n_fail == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
design/lkv_pkg.sv
design/lkv_cell.sv
design/lru_key_value_cache.sv
design/lkv_checker.sv
dv/tb_top.sv
